// ----- rtl/multi_pattern_byte_sequence_detector_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multi-pattern byte sequence detector
// Shared helpers that keep the checker's assertions short and uniform
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_BYTE_SEQUENCE_DETECTOR_DEFINES_SVH
`define MULTI_PATTERN_BYTE_SEQUENCE_DETECTOR_DEFINES_SVH

// property checked only while out of reset
`define MPBSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define MPBSD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mpbsd_pkg.sv -----
// ----------------------------------------------------------------------------
// mpbsd_pkg
// Shared constants, register codes and structs of the byte sequence detector
// ----------------------------------------------------------------------------
package mpbsd_pkg;

   localparam int NumPatterns   = 5;
   localparam int MaxPatternLen = 6;
   localparam int PatSlots      = 5;

   localparam int ByteW    = 8;
   localparam int PatW     = 48;
   localparam int LenW     = 3;
   localparam int LengthsW = 15;
   localparam int IndexW   = 3;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 48;

   // register reset values
   localparam logic [PatW-1:0] PatAReset = 48'd2431262;
   localparam logic [PatW-1:0] PatBReset = 48'd78099916319;
   localparam logic [PatW-1:0] PatCReset = 48'd623776291;
   localparam logic [PatW-1:0] PatDReset = 48'd3281458;
   localparam logic [PatW-1:0] PatEReset = 48'd20968367922738;
   localparam logic [LengthsW-1:0] LengthsReset = 15'd26411;
   localparam logic [LenW-1:0]     SpecialReset = 3'd6;
   localparam logic [ByteW-1:0]    ReplaceReset = 8'd42;

   // register indexes on the csr port
   typedef enum logic [CsrAddrW-1:0] {
      CSR_PATTERN_A   = 3'd0,
      CSR_PATTERN_B   = 3'd1,
      CSR_PATTERN_C   = 3'd2,
      CSR_PATTERN_D   = 3'd3,
      CSR_PATTERN_E   = 3'd4,
      CSR_LENGTHS     = 3'd5,
      CSR_SPECIAL_LEN = 3'd6,
      CSR_REPLACE     = 3'd7
   } csr_index_type;

   // configuration as seen by the match logic
   typedef struct packed {
      logic [PatSlots-1:0][PatW-1:0] pattern;
      logic [LengthsW-1:0]           lengths;
      logic [LenW-1:0]               special_len;
      logic [ByteW-1:0]              replace_byte;
   } cfg_type;

   // outcome of one byte
   typedef struct packed {
      logic              hit;
      logic [IndexW-1:0] index;
      logic              special;
      logic [ByteW-1:0]  out_byte;
   } match_type;

endpackage

// ----- rtl/mpbsd_csr.sv -----
// ----------------------------------------------------------------------------
// mpbsd_csr
// Configuration registers: patterns, lengths, special length, replacement byte
// ----------------------------------------------------------------------------
module mpbsd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mpbsd_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [mpbsd_pkg::CsrDataW-1:0] csr_wdata,
   output mpbsd_pkg::cfg_type             cfg
);

   mpbsd_pkg::cfg_type cfg_ff;
   mpbsd_pkg::cfg_type cfg_in;

   // decode one register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (mpbsd_pkg::csr_index_type'(csr_addr))
            mpbsd_pkg::CSR_PATTERN_A:   cfg_in.pattern[0] = csr_wdata[mpbsd_pkg::PatW-1:0];
            mpbsd_pkg::CSR_PATTERN_B:   cfg_in.pattern[1] = csr_wdata[mpbsd_pkg::PatW-1:0];
            mpbsd_pkg::CSR_PATTERN_C:   cfg_in.pattern[2] = csr_wdata[mpbsd_pkg::PatW-1:0];
            mpbsd_pkg::CSR_PATTERN_D:   cfg_in.pattern[3] = csr_wdata[mpbsd_pkg::PatW-1:0];
            mpbsd_pkg::CSR_PATTERN_E:   cfg_in.pattern[4] = csr_wdata[mpbsd_pkg::PatW-1:0];
            mpbsd_pkg::CSR_LENGTHS:     cfg_in.lengths = csr_wdata[mpbsd_pkg::LengthsW-1:0];
            mpbsd_pkg::CSR_SPECIAL_LEN: cfg_in.special_len = csr_wdata[mpbsd_pkg::LenW-1:0];
            mpbsd_pkg::CSR_REPLACE:     cfg_in.replace_byte = csr_wdata[mpbsd_pkg::ByteW-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   // register bank with its reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern[0]   <= mpbsd_pkg::PatAReset;
         cfg_ff.pattern[1]   <= mpbsd_pkg::PatBReset;
         cfg_ff.pattern[2]   <= mpbsd_pkg::PatCReset;
         cfg_ff.pattern[3]   <= mpbsd_pkg::PatDReset;
         cfg_ff.pattern[4]   <= mpbsd_pkg::PatEReset;
         cfg_ff.lengths      <= mpbsd_pkg::LengthsReset;
         cfg_ff.special_len  <= mpbsd_pkg::SpecialReset;
         cfg_ff.replace_byte <= mpbsd_pkg::ReplaceReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/mpbsd_match.sv -----
// ----------------------------------------------------------------------------
// mpbsd_match
// Per-pattern progress counters and the compare/priority logic for one byte
// ----------------------------------------------------------------------------
module mpbsd_match #(
   parameter int NUM_PATTERNS    = mpbsd_pkg::NumPatterns,
   parameter int MAX_PATTERN_LEN = mpbsd_pkg::MaxPatternLen
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mpbsd_pkg::cfg_type           cfg,
   input  logic [mpbsd_pkg::ByteW-1:0]  in_byte,
   input  logic                         fire,
   output mpbsd_pkg::match_type         result
);

   logic [NUM_PATTERNS-1:0][mpbsd_pkg::LenW-1:0] progress_ff;
   logic [NUM_PATTERNS-1:0][mpbsd_pkg::LenW-1:0] progress_in;
   logic [NUM_PATTERNS-1:0][mpbsd_pkg::LenW-1:0] progress_next;
   logic [NUM_PATTERNS-1:0][mpbsd_pkg::LenW-1:0] eff_len;
   logic [NUM_PATTERNS-1:0]                      done;

   // effective lengths, advance/clear each counter, find lowest completion
   always_comb begin
      logic [mpbsd_pkg::LenW-1:0]     raw_len;
      logic [63:0]                    pat64;
      logic [mpbsd_pkg::ByteW-1:0]    expect_byte;
      logic                           found;
      logic [mpbsd_pkg::IndexW-1:0]   win_idx;
      logic [mpbsd_pkg::LenW-1:0]     win_len;
      found   = 1'b0;
      win_idx = '0;
      win_len = '0;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
         raw_len = cfg.lengths[mpbsd_pkg::LenW*i +: mpbsd_pkg::LenW];
         if (raw_len > mpbsd_pkg::LenW'(MAX_PATTERN_LEN)) begin
            eff_len[i] = mpbsd_pkg::LenW'(MAX_PATTERN_LEN);
         end else begin
            eff_len[i] = raw_len;
         end
         pat64       = 64'(cfg.pattern[i]);
         expect_byte = pat64[{progress_ff[i], 3'b000} +: mpbsd_pkg::ByteW];
         if (eff_len[i] != '0 && progress_ff[i] < eff_len[i] && expect_byte == in_byte) begin
            progress_next[i] = progress_ff[i] + 1'b1;
         end else begin
            progress_next[i] = '0;
         end
         done[i] = (eff_len[i] != '0) && (progress_next[i] == eff_len[i]);
         if (done[i] && !found) begin
            found   = 1'b1;
            win_idx = mpbsd_pkg::IndexW'(i);
            win_len = eff_len[i];
         end
      end
      result.hit      = found && (in_byte != '0);
      result.index    = win_idx;
      result.special  = (win_len == cfg.special_len);
      result.out_byte = result.special ? cfg.replace_byte : in_byte;
   end

   // zero bytes leave the counters alone, a completion clears them all
   always_comb begin
      progress_in = progress_ff;
      if (fire && in_byte != '0) begin
         if (result.hit) begin
            progress_in = '0;
         end else begin
            progress_in = progress_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff <= '0;
      end else begin
         progress_ff <= progress_in;
      end
   end

endmodule

// ----- rtl/multi_pattern_byte_sequence_detector.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_byte_sequence_detector
// Watches a byte stream for configured patterns and reports each completion
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one byte per word (zero bytes are dropped without effect).
//   rsp_ carries one word per completed pattern: the byte (or the replacement
//   byte when the winning pattern has the special length), the index of the
//   lowest-numbered pattern that completed and the special-match flag.
//   csr_ writes one register per cycle by index; write only while idle.
// Path: an accepted byte lands in one input register; the compare logic between
//   it and one result register decides what the result register shows.
// Throughput: one byte per cycle unless a hit waits on a stalled result; the five
//   progress counters update in the same cycle the byte leaves the input register.
// Reset: counters clear, registers load their defaults, no word is pending.
// Stall: while rsp_tready is low the result holds; the input register still
//   drains bytes that complete nothing, refilling behind each, and holds a hit.
// ----------------------------------------------------------------------------
module multi_pattern_byte_sequence_detector #(
   parameter int NUM_PATTERNS    = mpbsd_pkg::NumPatterns,
   parameter int MAX_PATTERN_LEN = mpbsd_pkg::MaxPatternLen
) (
   input  logic                           clock,
   input  logic                           reset,
   // input byte stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // [7:0] in_byte
   // detection results
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,  // [7:0] out_byte
   output logic [3:0]                     rsp_tuser,  // [2:0] pattern_index, [3] special_match
   // configuration writes
   input  logic                           csr_we,
   input  logic [mpbsd_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [mpbsd_pkg::CsrDataW-1:0] csr_wdata
);

   mpbsd_pkg::cfg_type   cfg;
   mpbsd_pkg::match_type result;

   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [mpbsd_pkg::ByteW-1:0] in_byte_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [mpbsd_pkg::ByteW-1:0] rsp_byte_ff;
   logic [mpbsd_pkg::IndexW-1:0] rsp_index_ff;
   logic                        rsp_special_ff;
   logic                        out_free;
   logic                        in_advance;
   logic                        req_fire;

   mpbsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mpbsd_match #(
      .NUM_PATTERNS    (NUM_PATTERNS),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
   ) u_match (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .in_byte (in_byte_ff),
      .fire    (in_advance),
      .result  (result)
   );

   // handshake: the held byte moves on unless it hits and the result is stuck
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_advance = in_valid_ff && (out_free || !result.hit);
   assign req_tready = !reset && (!in_valid_ff || in_advance);
   assign req_fire   = req_tvalid && req_tready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = in_advance && result.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && in_advance && result.hit) begin
         rsp_byte_ff    <= result.out_byte;
         rsp_index_ff   <= result.index;
         rsp_special_ff <= result.special;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_special_ff, rsp_index_ff};

endmodule

// ----- rtl/mpbsd_checker.sv -----
// ----------------------------------------------------------------------------
// mpbsd_checker
// Port-level assertions for the detector, bound onto the top level
// ----------------------------------------------------------------------------
`include "multi_pattern_byte_sequence_detector_defines.svh"

module mpbsd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [7:0]                     req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [7:0]                     rsp_tdata,
   input logic [3:0]                     rsp_tuser,
   input logic                           csr_we,
   input logic [mpbsd_pkg::CsrAddrW-1:0] csr_addr,
   input logic [mpbsd_pkg::CsrDataW-1:0] csr_wdata
);

   logic req_word;
   logic rsp_stalled;

   assign req_word    = req_tvalid && req_tready;
   assign rsp_stalled = rsp_tvalid && !rsp_tready;

   // a stalled result holds its word
   `MPBSD_ASSERT(a_rsp_hold, clock, reset, rsp_stalled |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp word changed while stalled")

   // nothing is pending right after reset
   `MPBSD_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid, "rsp_tvalid set after reset")

   // a rising rsp_tvalid checks for an accepted byte through $past of req_word
   `MPBSD_ASSERT(a_rsp_source, clock, reset, $rose(rsp_tvalid) |-> $past(req_word, 2), "result without a byte two cycles before")

   // only real patterns win, and a passed-through byte is never zero
   `MPBSD_ASSERT(a_rsp_fields, clock, reset, rsp_tvalid |-> (rsp_tuser[2:0] <= 3'd4) && (rsp_tuser[3] || rsp_tdata != 8'd0), "bad result fields")

endmodule

bind multi_pattern_byte_sequence_detector mpbsd_checker u_mpbsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_we     (csr_we),
   .csr_addr   (csr_addr),
   .csr_wdata  (csr_wdata)
);
